// ----- src/min_segment_visibility_top_macros.svh -----
// Assertion macros shared by the segment visibility scorer.
`ifndef MIN_SEGMENT_VISIBILITY_TOP_MACROS_SVH
`define MIN_SEGMENT_VISIBILITY_TOP_MACROS_SVH

// expression must never hold outside reset
`define MSV_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define MSV_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/msv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the segment visibility scorer.
package msv_pkg;
    localparam int COORD_FRAC_BITS = 16;
    localparam int T_FRAC = 32;
    localparam int DW = 33;
    localparam int MW = 34;
    localparam int PW = 68;
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_DEPTH = 2;
    localparam logic [PW-1:0] SHORT_THRESH =
        ((PW'(1) << (2 * COORD_FRAC_BITS)) + PW'(99999)) / PW'(100000);
    localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (T_FRAC - 1);
    localparam logic [DW-1:0] T_ONE = DW'(1) << T_FRAC;
    localparam logic [31:0] SCORE_MAX = '1;

    typedef enum logic [1:0] {
        KIND_KEEPER = 2'd0,
        KIND_TGT1   = 2'd1,
        KIND_TGT2   = 2'd2,
        KIND_POINT  = 2'd3
    } t_kind;

    typedef logic [2:0][DW-1:0] t_vec3;

    typedef struct packed {
        t_vec3 d1;
        t_vec3 w1;
        t_vec3 d2;
        t_vec3 w2;
        logic  dual;
        logic  last;
        logic  emit;
    } t_job;

    typedef enum logic [1:0] {MS_IDLE, MS_LO, MS_HI, MS_SUM} t_mul_state;

    typedef enum logic [1:0] {OP_DD, OP_WD, OP_TD, OP_EE} t_op;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_MUL, ST_MWAIT, ST_DECIDE, ST_DIV, ST_ROOT, ST_DONE
    } t_state;
endpackage

// ----- src/msv_mul.sv -----
`timescale 1ns / 1ps
// Multi-cycle 34x34 unsigned multiplier built from two 34x17 partial products.
module msv_mul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [msv_pkg::MW-1:0]  i_a,
    input  logic [msv_pkg::MW-1:0]  i_b,
    output logic                    o_done,
    output logic [msv_pkg::PW-1:0]  o_prod
);
    import msv_pkg::*;

    localparam int HW = MW / 2;

    t_mul_state r_state, n_state;
    logic [MW-1:0] r_a, r_b;
    logic [MW+HW-1:0] r_lo, r_hi;
    logic [PW-1:0] r_prod;
    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == MS_SUM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == MS_IDLE && i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_state == MS_LO) begin
            r_lo <= {{HW{1'b0}}, r_a} * {{MW{1'b0}}, r_b[HW-1:0]};
        end
        if (r_state == MS_HI) begin
            r_hi <= {{HW{1'b0}}, r_a} * {{MW{1'b0}}, r_b[MW-1:HW]};
        end
        if (r_state == MS_SUM) begin
            r_prod <= PW'(r_lo) + (PW'(r_hi) << HW);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MS_IDLE: begin
                if (i_start) n_state = MS_LO;
            end
            MS_LO:  n_state = MS_HI;
            MS_HI:  n_state = MS_SUM;
            MS_SUM: n_state = MS_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule

// ----- src/msv_div.sv -----
`timescale 1ns / 1ps
// Restoring divider for the projection fraction, one quotient bit per cycle.
module msv_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [msv_pkg::PW-1:0]  i_num,
    input  logic [msv_pkg::PW-1:0]  i_den,
    output logic                    o_done,
    output logic [msv_pkg::DW-1:0]  o_quot
);
    import msv_pkg::*;

    localparam int CW = $clog2(T_FRAC);

    logic r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_rem, r_den;
    logic [T_FRAC-1:0] r_quot;
    logic [PW:0] sh;
    logic ge;

    // numerator is below the divisor, so the remainder stays below it
    assign sh = {r_rem, 1'b0};
    assign ge = sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(T_FRAC - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? PW'(sh - {1'b0, r_den}) : sh[PW-1:0];
            r_quot <= {r_quot[T_FRAC-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = DW'(r_quot);
endmodule

// ----- src/msv_sqrt.sv -----
`timescale 1ns / 1ps
// Digit-by-digit integer square root, two radicand bits per cycle, saturating.
module msv_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [msv_pkg::PW-1:0]  i_rad,
    output logic                    o_done,
    output logic [31:0]             o_score
);
    import msv_pkg::*;

    localparam int STEPS = PW / 2;
    localparam int CW = $clog2(STEPS);
    localparam int RW = MW + 4;

    logic r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_rad;
    logic [RW-1:0] r_rem;
    logic [MW-1:0] r_root;
    logic [RW-1:0] rem2, trial;
    logic ge;

    assign rem2  = {r_rem[RW-3:0], r_rad[PW-1:PW-2]};
    assign trial = {{(RW-MW-2){1'b0}}, r_root, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= ge ? rem2 - trial : rem2;
            r_root <= {r_root[MW-2:0], ge};
        end
    end

    assign o_done  = r_done;
    assign o_score = (|r_root[MW-1:32]) ? SCORE_MAX : r_root[31:0];
endmodule

// ----- src/msv_front.sv -----
`timescale 1ns / 1ps
// Front end: input acceptance, pose registers, difference vectors, job queue.
module msv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_kind,
    input  logic signed [31:0]  i_coord_x,
    input  logic signed [31:0]  i_coord_y,
    input  logic signed [31:0]  i_coord_z,
    input  logic                i_last,
    input  logic                i_cfg_we,
    input  logic                i_cfg_dual_target,
    input  logic                i_job_pop,
    output logic                o_job_valid,
    output msv_pkg::t_job       o_job
);
    import msv_pkg::*;

    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [DW-1:0] sext(logic [31:0] v);
        return {v[31], v};
    endfunction

    logic [2:0][31:0] r_keeper, r_tgt1, r_tgt2;
    logic [2:0] r_pose_valid;
    logic r_dual;
    t_job r_mem [QUEUE_DEPTH];
    logic [QPW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_count;

    logic [2:0][31:0] pt;
    logic [2:0] need;
    logic accept, job_push;
    t_job n_job;

    assign pt       = {i_coord_z, i_coord_y, i_coord_x};
    assign full     = (r_count == QCW'(QUEUE_DEPTH));
    assign accept   = push && !full;
    assign job_push = accept && (t_kind'(i_kind) == KIND_POINT);
    assign need     = r_dual ? 3'b111 : 3'b011;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_job.d1[i] = sext(r_keeper[i]) - sext(r_tgt1[i]);
            n_job.w1[i] = sext(pt[i]) - sext(r_tgt1[i]);
            n_job.d2[i] = sext(r_keeper[i]) - sext(r_tgt2[i]);
            n_job.w2[i] = sext(pt[i]) - sext(r_tgt2[i]);
        end
        n_job.dual = r_dual;
        n_job.last = i_last;
        n_job.emit = i_last && ((r_pose_valid & need) == need);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keeper     <= '0;
            r_tgt1       <= '0;
            r_tgt2       <= '0;
            r_pose_valid <= '0;
            r_dual       <= 1'b0;
            r_wr         <= '0;
            r_rd         <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we) r_dual <= i_cfg_dual_target;
            if (accept) begin
                unique case (t_kind'(i_kind))
                    KIND_KEEPER: begin
                        r_keeper        <= pt;
                        r_pose_valid[0] <= 1'b1;
                    end
                    KIND_TGT1: begin
                        r_tgt1          <= pt;
                        r_pose_valid[1] <= 1'b1;
                    end
                    KIND_TGT2: begin
                        r_tgt2          <= pt;
                        r_pose_valid[2] <= 1'b1;
                    end
                    KIND_POINT: begin
                    end
                endcase
            end
            if (job_push) r_wr <= r_wr + 1'b1;
            if (i_job_pop) r_rd <= r_rd + 1'b1;
            if (job_push && !i_job_pop) r_count <= r_count + 1'b1;
            else if (!job_push && i_job_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_push) r_mem[r_wr] <= n_job;
    end

    assign o_job_valid = (r_count != '0);
    assign o_job       = r_mem[r_rd];
endmodule

// ----- src/msv_back.sv -----
`timescale 1ns / 1ps
`include "min_segment_visibility_top_macros.svh"
// Back end: per-target distance sequencer, running minimum, result queue.
module msv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  msv_pkg::t_job   i_job,
    output logic            o_job_pop,
    output logic            empty,
    input  logic            pop,
    output logic [31:0]     o_min_score
);
    import msv_pkg::*;

    localparam int OPW = $clog2(OUT_DEPTH);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    function automatic logic [DW-1:0] mag(logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    t_state r_state, n_state;
    t_op r_op;
    logic [1:0] r_ax;
    logic r_tsel;
    logic [31:0] r_min;
    logic [DW-1:0] r_dmag [3];
    logic [DW-1:0] r_wmag [3];
    logic [DW-1:0] r_w [3];
    logic [2:0] r_dneg;
    logic [PW-1:0] r_seg2, r_pos, r_neg, r_dist2;
    logic [DW-1:0] r_t, r_q;
    logic [31:0] r_ofifo [OUT_DEPTH];
    logic [OPW-1:0] r_owr, r_ord;
    logic [OCW-1:0] r_ocnt;

    logic mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] prod, dotm, sqrt_rad, rnd;
    logic [DW-1:0] quot;
    logic [31:0] score;
    t_vec3 sel_d, sel_w;
    logic [DW+1:0] e_val;
    logic [MW-1:0] e_mag;
    logic short_seg, out_full, out_push, job_pop, out_pop;

    assign sel_d     = r_tsel ? i_job.d2 : i_job.d1;
    assign sel_w     = r_tsel ? i_job.w2 : i_job.w1;
    assign dotm      = r_pos - r_neg;
    assign short_seg = r_seg2 < SHORT_THRESH;
    assign rnd       = prod + ROUND_HALF;
    assign out_full  = (r_ocnt == OCW'(OUT_DEPTH));
    assign out_pop   = pop && !empty;

    // residual w - projected offset, offset takes the sign of d
    always_comb begin
        logic [DW+1:0] w_ext, off_ext;
        w_ext   = {{2{r_w[r_ax][DW-1]}}, r_w[r_ax]};
        off_ext = {2'b00, r_q};
        e_val   = r_dneg[r_ax] ? w_ext + off_ext : w_ext - off_ext;
        e_mag   = e_val[DW+1] ? MW'(~e_val + 1'b1) : MW'(e_val);
    end

    always_comb begin
        unique case (r_op)
            OP_DD: begin
                mul_a = MW'(r_dmag[r_ax]);
                mul_b = MW'(r_dmag[r_ax]);
            end
            OP_WD: begin
                mul_a = MW'(r_wmag[r_ax]);
                mul_b = MW'(r_dmag[r_ax]);
            end
            OP_TD: begin
                mul_a = MW'(r_t);
                mul_b = MW'(r_dmag[r_ax]);
            end
            OP_EE: begin
                mul_a = e_mag;
                mul_b = e_mag;
            end
        endcase
    end

    assign sqrt_rad = (r_state == ST_DECIDE) ? r_seg2 : r_dist2 + prod;

    always_comb begin
        n_state    = r_state;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        job_pop    = 1'b0;
        out_push   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid && !out_full) n_state = ST_LOAD;
            end
            ST_LOAD: n_state = ST_MUL;
            ST_MUL: begin
                mul_start = 1'b1;
                n_state   = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (mul_done) begin
                    unique case (r_op)
                        OP_DD, OP_TD: n_state = ST_MUL;
                        OP_WD: n_state = (r_ax == 2'd2) ? ST_DECIDE : ST_MUL;
                        OP_EE: begin
                            if (r_ax == 2'd2) begin
                                sqrt_start = 1'b1;
                                n_state    = ST_ROOT;
                            end else begin
                                n_state = ST_MUL;
                            end
                        end
                    endcase
                end
            end
            ST_DECIDE: begin
                if (short_seg) begin
                    sqrt_start = 1'b1;
                    n_state    = ST_ROOT;
                end else if (r_pos <= r_neg || r_seg2 <= dotm) begin
                    n_state = ST_MUL;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) n_state = ST_MUL;
            end
            ST_ROOT: begin
                if (sqrt_done) n_state = (!r_tsel && i_job.dual) ? ST_LOAD : ST_DONE;
            end
            ST_DONE: begin
                job_pop  = 1'b1;
                out_push = i_job.last && i_job.emit;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tsel  <= 1'b0;
            r_min   <= SCORE_MAX;
            r_owr   <= '0;
            r_ord   <= '0;
            r_ocnt  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) r_tsel <= 1'b0;
            if (r_state == ST_ROOT && sqrt_done) begin
                if (score < r_min) r_min <= score;
                if (n_state == ST_LOAD) r_tsel <= 1'b1;
            end
            if (r_state == ST_DONE && i_job.last) r_min <= SCORE_MAX;
            if (out_push) r_owr <= r_owr + 1'b1;
            if (out_pop) r_ord <= r_ord + 1'b1;
            if (out_push && !out_pop) r_ocnt <= r_ocnt + 1'b1;
            else if (!out_push && out_pop) r_ocnt <= r_ocnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) r_ofifo[r_owr] <= r_min;
        unique case (r_state)
            ST_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_dmag[i] <= mag(sel_d[i]);
                    r_wmag[i] <= mag(sel_w[i]);
                    r_w[i]    <= sel_w[i];
                    r_dneg[i] <= sel_d[i][DW-1];
                end
                r_seg2  <= '0;
                r_pos   <= '0;
                r_neg   <= '0;
                r_dist2 <= '0;
                r_ax    <= '0;
                r_op    <= OP_DD;
            end
            ST_MWAIT: begin
                if (mul_done) begin
                    unique case (r_op)
                        OP_DD: begin
                            r_seg2 <= r_seg2 + prod;
                            r_op   <= OP_WD;
                        end
                        OP_WD: begin
                            if (r_w[r_ax][DW-1] != r_dneg[r_ax]) r_neg <= r_neg + prod;
                            else r_pos <= r_pos + prod;
                            if (r_ax != 2'd2) begin
                                r_ax <= r_ax + 1'b1;
                                r_op <= OP_DD;
                            end
                        end
                        OP_TD: begin
                            r_q  <= rnd[T_FRAC+DW-1:T_FRAC];
                            r_op <= OP_EE;
                        end
                        OP_EE: begin
                            r_dist2 <= r_dist2 + prod;
                            if (r_ax != 2'd2) begin
                                r_ax <= r_ax + 1'b1;
                                r_op <= OP_TD;
                            end
                        end
                    endcase
                end
            end
            ST_DECIDE: begin
                r_ax <= '0;
                r_op <= OP_TD;
                r_t  <= (r_pos <= r_neg) ? '0 : T_ONE;
            end
            ST_DIV: begin
                if (div_done) r_t <= quot;
            end
            default: begin
            end
        endcase
    end

    msv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    msv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (dotm),
        .i_den   (r_seg2),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    msv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (sqrt_rad),
        .o_done  (sqrt_done),
        .o_score (score)
    );

    assign o_job_pop   = job_pop;
    assign empty       = (r_ocnt == '0);
    assign o_min_score = r_ofifo[r_ord];

    `MSV_NEVER(a_out_overflow, i_clk, i_rst_n, out_push && out_full)
    `MSV_NEVER(a_pop_without_job, i_clk, i_rst_n, job_pop && !i_job_valid)
    `MSV_IMPLY(a_min_cleared, i_clk, i_rst_n, r_state == ST_DONE && i_job.last, r_min == SCORE_MAX)
endmodule

// ----- src/min_segment_visibility_top.sv -----
`timescale 1ns / 1ps
// Top level of the segment visibility scorer.
// Pose words (keeper, target one, target two) are taken in one cycle each
// while the input queue is not full. An obstacle word is scored against each
// active target segment by a sequencer that runs twelve products (six for a
// short segment) through one shared multi-cycle multiplier, with a divide for
// the projection fraction when it is not clamped to zero or one, then a square
// root. A two-word queue sits between the front end and the sequencer and a
// two-word queue holds results, so input keeps flowing while a result waits.
// The frame minimum is emitted on the last point of a frame only once the
// needed poses have arrived; it restarts at all ones.
module min_segment_visibility_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_kind,
    input  logic signed [31:0]  i_coord_x,
    input  logic signed [31:0]  i_coord_y,
    input  logic signed [31:0]  i_coord_z,
    input  logic                i_last,
    input  logic                i_cfg_we,
    input  logic                i_cfg_dual_target,
    output logic                empty,
    input  logic                pop,
    output logic [31:0]         o_min_score
);
    import msv_pkg::*;

    t_job job;
    logic job_valid, job_pop;

    msv_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_kind            (i_kind),
        .i_coord_x         (i_coord_x),
        .i_coord_y         (i_coord_y),
        .i_coord_z         (i_coord_z),
        .i_last            (i_last),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_dual_target (i_cfg_dual_target),
        .i_job_pop         (job_pop),
        .o_job_valid       (job_valid),
        .o_job             (job)
    );

    msv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .empty       (empty),
        .pop         (pop),
        .o_min_score (o_min_score)
    );
endmodule
